[sv/srp_pkg.sv]
// ----------------------------------------------------------------------------
// srp_pkg: shared types and constants of the s-record parser
// word formats, result codes, command codes, parser phases, address map, crc step
// ----------------------------------------------------------------------------
package srp_pkg;

	localparam int unsigned AddrW = 18;
	localparam int unsigned MaxW = 19;
	localparam logic [MaxW-1:0] MaxAddrReset = 19'h40000;
	localparam int unsigned QueueDepth = 2;

	typedef enum logic [1:0] {
		CMD_CHAR = 2'd0,
		CMD_RESTART = 2'd1,
		CMD_END = 2'd2,
		CMD_NOP = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		K_WRITE = 3'd0,
		K_PARSE = 3'd1,
		K_ADDR = 3'd2,
		K_CSUM = 3'd3,
		K_NONE = 3'd4,
		K_DONE = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_TYPE = 3'd1,
		PH_SKIP = 3'd2,
		PH_LEN = 3'd3,
		PH_ADDR = 3'd4,
		PH_DATA = 3'd5,
		PH_CSUM = 3'd6
	} phase_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] char_byte;
	} in_word_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [17:0] write_address;
		logic [7:0] write_data;
		logic [15:0] crc_value;
		logic [31:0] total_bytes;
		logic [23:0] line_number;
		logic [17:0] lowest_address;
		logic [17:0] highest_address;
	} out_word_t;

	// classified character handed from front to back
	typedef struct packed {
		cmd_t cmd;
		logic [7:0] ch;
		logic is_hex;
		logic [3:0] nib;
	} tok_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [AddrW:0] map_address(input logic [31:0] raw);
		if ((raw >= 32'h4000 && raw <= 32'h7FFF) || (raw >= 32'hC000 && raw <= 32'hFFFF)) begin
			return {3'b011, raw[15:0]};
		end
		return {1'b0, raw[19:16], raw[13:0]};
	endfunction

endpackage

[sv/srp_front.sv]
// ----------------------------------------------------------------------------
// srp_front: input stage and character classifier
// takes input words, decodes hex digits, pushes tokens into a small fifo
// ----------------------------------------------------------------------------
module srp_front (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic stall,
	input srp_pkg::in_word_t data,
	output logic tok_valid,
	input logic tok_pop,
	output srp_pkg::tok_t tok
);
	import srp_pkg::*;

	localparam int unsigned PtrW = $clog2(QueueDepth);

	tok_t mem_q [QueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [PtrW:0] cnt_q;
	tok_t t;
	logic push;

	always_comb begin
		t.cmd = cmd_t'(data.command);
		t.ch = data.char_byte;
		t.is_hex = 1'b1;
		t.nib = 4'd0;
		if (data.char_byte >= 8'h30 && data.char_byte <= 8'h39) begin
			t.nib = 4'(data.char_byte - 8'h30);
		end else if (data.char_byte >= 8'h61 && data.char_byte <= 8'h66) begin
			t.nib = 4'(data.char_byte - 8'h57);
		end else if (data.char_byte >= 8'h41 && data.char_byte <= 8'h46) begin
			t.nib = 4'(data.char_byte - 8'h37);
		end else begin
			t.is_hex = 1'b0;
		end
	end

	assign stall = (cnt_q == (PtrW+1)'(QueueDepth));
	assign push = valid && !stall;
	assign tok_valid = (cnt_q != '0);
	assign tok = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= PtrW'((32'(wr_q) + 1) % QueueDepth);
			if (tok_pop) rd_q <= PtrW'((32'(rd_q) + 1) % QueueDepth);
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(tok_pop);
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PtrW+1)'(QueueDepth)) else $error("fifo overflow");
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		tok_pop |-> tok_valid) else $error("pop from empty fifo");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !tok_pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");

endmodule

[sv/srp_back.sv]
// ----------------------------------------------------------------------------
// srp_back: record parser state machine
// consumes tokens, keeps parse state, crc and counters, registers result words
// ----------------------------------------------------------------------------
module srp_back (
	input logic clk,
	input logic arst_n,
	input logic tok_valid,
	output logic tok_pop,
	input srp_pkg::tok_t tok,
	input logic [srp_pkg::MaxW-1:0] addr_limit,
	output logic valid,
	input logic stall,
	output srp_pkg::out_word_t data
);
	import srp_pkg::*;

	phase_t phase_q, phase_d;
	logic [3:0] adig_q, adig_d, dcnt_q, dcnt_d;
	logic [31:0] fval_q, fval_d;
	logic [7:0] left_q, left_d, sum_q, sum_d;
	logic [AddrW:0] cur_q, cur_d;
	logic [15:0] crc_q, crc_d;
	logic [31:0] tot_q, tot_d;
	logic [23:0] line_q, line_d;
	logic [AddrW-1:0] lo_q, lo_d, hi_q, hi_d;
	logic fin_q, fin_d, halt_q, halt_d;
	logic ov_q;
	out_word_t ow_q;
	logic emit;
	kind_t ek;
	logic [AddrW-1:0] ea;
	logic [7:0] ed;
	logic [31:0] fv;
	logic [3:0] need;
	logic [AddrW:0] maddr;

	// results go into a one-word output register; token popped when it is free
	assign tok_pop = tok_valid && (!ov_q || !stall);
	assign valid = ov_q;
	assign data = ow_q;

	function automatic logic addr_ok(input logic [AddrW:0] a, input logic [MaxW-1:0] m);
		return !a[AddrW] && (MaxW'(a) < m);
	endfunction

	always_comb begin
		phase_d = phase_q; adig_d = adig_q; dcnt_d = dcnt_q; fval_d = fval_q;
		left_d = left_q; sum_d = sum_q; cur_d = cur_q; crc_d = crc_q; tot_d = tot_q;
		line_d = line_q; lo_d = lo_q; hi_d = hi_q; fin_d = fin_q; halt_d = halt_q;
		emit = 1'b0; ek = K_WRITE; ea = '0; ed = '0;
		fv = {fval_q[27:0], tok.nib};
		need = (phase_q == PH_ADDR) ? adig_q : 4'd2;
		maddr = map_address(fv);
		unique case (tok.cmd)
			CMD_RESTART: begin
				phase_d = PH_START; adig_d = '0; dcnt_d = '0; fval_d = '0;
				left_d = '0; sum_d = '0; cur_d = '0; crc_d = '0; tot_d = '0;
				line_d = '0; lo_d = '1; hi_d = '0; fin_d = 1'b0; halt_d = 1'b0;
			end
			CMD_NOP: ;
			CMD_END: begin
				if (!halt_q) begin
					emit = 1'b1;
					if (!fin_q && phase_q == PH_CSUM) begin
						ek = K_CSUM; halt_d = 1'b1;
					end else if (!fin_q && (phase_q == PH_LEN || phase_q == PH_ADDR
							|| phase_q == PH_DATA)) begin
						ek = K_PARSE; halt_d = 1'b1;
					end else begin
						fin_d = 1'b1;
						ek = (tot_q == '0) ? K_NONE : K_DONE;
					end
				end
			end
			CMD_CHAR: begin
				if (!halt_q && !fin_q) begin
					unique case (phase_q)
						PH_START: begin
							if (line_q != 24'hFFFFFF) line_d = line_q + 24'd1;
							phase_d = (tok.ch == 8'h0A) ? PH_START :
								(tok.ch == 8'h53) ? PH_TYPE : PH_SKIP;
						end
						PH_TYPE: begin
							if (tok.ch == 8'h0A) begin
								phase_d = PH_START;
							end else if (tok.ch >= 8'h31 && tok.ch <= 8'h33) begin
								adig_d = 4'((tok.ch - 8'h2F) << 1);
								dcnt_d = '0; fval_d = '0; phase_d = PH_LEN;
							end else if (tok.ch >= 8'h37 && tok.ch <= 8'h39) begin
								fin_d = 1'b1; phase_d = PH_SKIP;
							end else begin
								phase_d = PH_SKIP;
							end
						end
						PH_SKIP: begin
							if (tok.ch == 8'h0A) phase_d = PH_START;
						end
						default: begin
							if (!tok.is_hex) begin
								emit = 1'b1; halt_d = 1'b1;
								ek = (phase_q == PH_CSUM) ? K_CSUM : K_PARSE;
							end else if (dcnt_q + 4'd1 < need) begin
								fval_d = fv; dcnt_d = dcnt_q + 4'd1;
							end else begin
								fval_d = '0; dcnt_d = '0;
								unique case (phase_q)
									PH_LEN: begin
										left_d = fv[7:0]; sum_d = fv[7:0]; phase_d = PH_ADDR;
									end
									PH_ADDR: begin
										if (left_q < 8'(adig_q[3:1]) + 8'd1) begin
											emit = 1'b1; ek = K_PARSE; halt_d = 1'b1;
										end else begin
											sum_d = sum_q + fv[7:0] + fv[15:8] + fv[23:16] + fv[31:24];
											cur_d = maddr;
											if (!addr_ok(maddr, addr_limit)) begin
												emit = 1'b1; ek = K_ADDR; halt_d = 1'b1;
											end else begin
												left_d = left_q - (8'(adig_q[3:1]) + 8'd1);
												phase_d = (left_d != 0) ? PH_DATA : PH_CSUM;
											end
										end
									end
									PH_DATA: begin
										if (!addr_ok(cur_q, addr_limit)) begin
											emit = 1'b1; ek = K_ADDR; halt_d = 1'b1;
										end else begin
											sum_d = sum_q + fv[7:0];
											if (tot_q != '1) tot_d = tot_q + 32'd1;
											crc_d = crc_byte(crc_q, fv[7:0]);
											if (cur_q[AddrW-1:0] < lo_q) lo_d = cur_q[AddrW-1:0];
											if (cur_q[AddrW-1:0] > hi_q) hi_d = cur_q[AddrW-1:0];
											cur_d = cur_q + 1'b1;
											left_d = left_q - 8'd1;
											if (left_d == 0) phase_d = PH_CSUM;
											emit = 1'b1; ea = cur_q[AddrW-1:0]; ed = fv[7:0];
										end
									end
									default: begin
										if (sum_q + fv[7:0] != 8'hFF) begin
											emit = 1'b1; ek = K_CSUM; halt_d = 1'b1;
										end else begin
											phase_d = PH_SKIP;
										end
									end
								endcase
							end
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tok_pop && emit) begin
			ow_q <= '{kind: ek, write_address: ea, write_data: ed, crc_value: crc_d,
				total_bytes: tot_d, line_number: line_d, lowest_address: lo_d,
				highest_address: hi_d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START; adig_q <= '0; dcnt_q <= '0; fval_q <= '0;
			left_q <= '0; sum_q <= '0; cur_q <= '0; crc_q <= '0; tot_q <= '0;
			line_q <= '0; lo_q <= '1; hi_q <= '0; fin_q <= 1'b0; halt_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (tok_pop) begin
				phase_q <= phase_d; adig_q <= adig_d; dcnt_q <= dcnt_d; fval_q <= fval_d;
				left_q <= left_d; sum_q <= sum_d; cur_q <= cur_d; crc_q <= crc_d;
				tot_q <= tot_d; line_q <= line_d; lo_q <= lo_d; hi_q <= hi_d;
				fin_q <= fin_d; halt_q <= halt_d;
			end
			if (tok_pop) ov_q <= emit;
			else if (!stall) ov_q <= 1'b0;
		end
	end

	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_pop && halt_q && tok.cmd == CMD_CHAR) |=> !ov_q) else $error("output while halted");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && stall) |=> ov_q && $stable(ow_q)) else $error("result lost");
	a_tot: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_pop && tok.cmd == CMD_CHAR) |=> tot_q >= $past(tot_q)) else $error("count went back");

endmodule

[sv/s_record_parser_with_crc_core.sv]
// ----------------------------------------------------------------------------
// s_record_parser_with_crc_core: s-record text parser with crc-16
// parses s1/s2/s3 records into paged image writes with crc and checksum check
// ----------------------------------------------------------------------------
// channel   dir  handshake          word
// in        in   in_valid/in_stall  srp_pkg::in_word_t (command, char_byte)
// out       out  out_valid/out_stall srp_pkg::out_word_t (result fields)
// apb       in   psel/penable       addr_limit at byte address 0
//
// one word per cycle sustained while out_stall is low; a word passes the input
// fifo, then the parser step that loads the output register
// the parser step is the state update including one crc byte
// reset clears fifo, parse state and sets addr_limit to 0x40000
// out_stall holds the output word; the fifo keeps taking input until full
// ----------------------------------------------------------------------------
module s_record_parser_with_crc_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input srp_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_stall,
	output srp_pkg::out_word_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import srp_pkg::*;

	logic [MaxW-1:0] max_q;
	logic tok_valid, tok_pop;
	tok_t tok;

	// register file: only addr_limit
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {13'd0, max_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MaxAddrReset;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			max_q <= pwdata[MaxW-1:0];
		end
	end

	// front: takes and classifies words
	srp_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall), .data(in_data),
		.tok_valid(tok_valid), .tok_pop(tok_pop), .tok(tok)
	);

	// back: parser, crc and result register
	srp_back u_back (
		.clk(clk), .arst_n(arst_n), .tok_valid(tok_valid), .tok_pop(tok_pop), .tok(tok),
		.addr_limit(max_q), .valid(out_valid), .stall(out_stall), .data(out_data)
	);

endmodule

[tb/tb_s_record_parser_with_crc_core.sv]
// ----------------------------------------------------------------------------
// tb_s_record_parser_with_crc_core: testbench of the s-record parser
// drives s-record text words with random bursts and gaps, stalls the result
// side on its own pattern, predicts every result word and checks it field by field
// ----------------------------------------------------------------------------
module tb_s_record_parser_with_crc_core;
	import srp_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_word_t in_data;
	logic out_valid;
	logic out_stall;
	out_word_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	s_record_parser_with_crc_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// register index of addr_limit
	localparam int unsigned RegMaxAddr = 0;

	// predictor state, a private copy of the parser
	logic [18:0] pr_max;
	phase_t pr_phase;
	logic [3:0] pr_adigits;
	logic [3:0] pr_dcount;
	logic [31:0] pr_field;
	logic [7:0] pr_left;
	logic [7:0] pr_sum;
	logic [18:0] pr_addr;
	logic [15:0] pr_crc;
	logic [31:0] pr_total;
	logic [23:0] pr_lines;
	logic [17:0] pr_low;
	logic [17:0] pr_high;
	logic pr_finished;
	logic pr_halted;

	out_word_t expected_results[$];
	int errors;
	int results_seen;
	int kind_seen[6];
	bit long_hold;
	int long_hold_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// generous overall limit
	initial begin
		#(12 * 400000);
		$display("tb_s_record_parser_with_crc_core NOT OK");
		$finish;
	end

	task automatic clear_parser();
		pr_phase = PH_START;
		pr_adigits = '0;
		pr_dcount = '0;
		pr_field = '0;
		pr_left = '0;
		pr_sum = '0;
		pr_addr = '0;
		pr_crc = '0;
		pr_total = '0;
		pr_lines = '0;
		pr_low = 18'h3FFFF;
		pr_high = '0;
		pr_finished = 1'b0;
		pr_halted = 1'b0;
	endtask

	function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		return c;
	endfunction

	function automatic logic [18:0] page_map(logic [31:0] raw);
		if ((raw >= 32'h4000 && raw <= 32'h7FFF) || (raw >= 32'hC000 && raw <= 32'hFFFF))
			return 19'((raw & 32'hFFFF) | 32'h30000);
		return 19'((raw & 32'h3FFF) | ((raw & 32'hF0000) >> 2));
	endfunction

	function automatic bit in_range(logic [18:0] a);
		return a <= 19'h3FFFF && a < pr_max;
	endfunction

	// queue one expected result word from the current running values
	task automatic push_result(kind_t k, logic [17:0] a, logic [7:0] d);
		out_word_t w;
		w.kind = k;
		w.write_address = a;
		w.write_data = d;
		w.crc_value = pr_crc;
		w.total_bytes = pr_total;
		w.line_number = pr_lines;
		w.lowest_address = pr_low;
		w.highest_address = pr_high;
		expected_results.push_back(w);
	endtask

	task automatic halt_with(kind_t k);
		pr_halted = 1'b1;
		push_result(k, '0, '0);
	endtask

	// parser step for one accepted word
	task automatic parse_word(in_word_t w);
		logic [4:0] nib;
		logic [31:0] fv;
		logic [3:0] need;
		logic [7:0] ch;
		ch = w.char_byte;
		if (w.command == CMD_RESTART) begin
			clear_parser();
			return;
		end
		if (w.command == CMD_NOP) return;
		if (w.command == CMD_END) begin
			if (pr_halted) return;
			if (!pr_finished) begin
				if (pr_phase == PH_CSUM) begin
					halt_with(K_CSUM);
					return;
				end
				if (pr_phase inside {PH_LEN, PH_ADDR, PH_DATA}) begin
					halt_with(K_PARSE);
					return;
				end
			end
			pr_finished = 1'b1;
			push_result(pr_total == 0 ? K_NONE : K_DONE, '0, '0);
			return;
		end
		if (pr_halted || pr_finished) return;
		case (pr_phase)
			PH_START: begin
				if (pr_lines != 24'hFFFFFF) pr_lines++;
				pr_phase = (ch == "\n") ? PH_START : (ch == "S") ? PH_TYPE : PH_SKIP;
				return;
			end
			PH_TYPE: begin
				if (ch == "\n") pr_phase = PH_START;
				else if (ch >= "1" && ch <= "3") begin
					pr_adigits = 4'((ch - "0" + 1) * 2);
					pr_dcount = '0;
					pr_field = '0;
					pr_phase = PH_LEN;
				end else if (ch >= "7" && ch <= "9") begin
					pr_finished = 1'b1;
					pr_phase = PH_SKIP;
				end else pr_phase = PH_SKIP;
				return;
			end
			PH_SKIP: begin
				if (ch == "\n") pr_phase = PH_START;
				return;
			end
			default: ;
		endcase
		if (ch >= "0" && ch <= "9") nib = 5'(ch - "0");
		else if (ch >= "a" && ch <= "f") nib = 5'(ch - "a" + 10);
		else if (ch >= "A" && ch <= "F") nib = 5'(ch - "A" + 10);
		else nib = 5'd16;
		if (nib > 15) begin
			halt_with(pr_phase == PH_CSUM ? K_CSUM : K_PARSE);
			return;
		end
		pr_field = (pr_field << 4) | 32'(nib[3:0]);
		pr_dcount++;
		need = (pr_phase == PH_ADDR) ? pr_adigits : 4'd2;
		if (pr_dcount < need) return;
		fv = pr_field;
		pr_dcount = '0;
		pr_field = '0;
		case (pr_phase)
			PH_LEN: begin
				pr_left = fv[7:0];
				pr_sum = fv[7:0];
				pr_phase = PH_ADDR;
			end
			PH_ADDR: begin
				need = 4'(pr_adigits / 2 + 1);
				if (pr_left < 8'(need)) begin
					halt_with(K_PARSE);
					return;
				end
				pr_sum = pr_sum + fv[7:0] + fv[15:8] + fv[23:16] + fv[31:24];
				pr_addr = page_map(fv);
				if (!in_range(pr_addr)) begin
					halt_with(K_ADDR);
					return;
				end
				pr_left = pr_left - 8'(need);
				pr_phase = pr_left != 0 ? PH_DATA : PH_CSUM;
			end
			PH_DATA: begin
				if (!in_range(pr_addr)) begin
					halt_with(K_ADDR);
					return;
				end
				pr_sum = pr_sum + fv[7:0];
				if (pr_total != 32'hFFFFFFFF) pr_total++;
				pr_crc = crc16_update(pr_crc, fv[7:0]);
				if (pr_addr[17:0] < pr_low) pr_low = pr_addr[17:0];
				if (pr_addr[17:0] > pr_high) pr_high = pr_addr[17:0];
				push_result(K_WRITE, pr_addr[17:0], fv[7:0]);
				pr_addr = pr_addr + 19'd1;
				pr_left = pr_left - 8'd1;
				if (pr_left == 0) pr_phase = PH_CSUM;
			end
			PH_CSUM: begin
				if (8'(pr_sum + fv[7:0]) != 8'hFF) begin
					halt_with(K_CSUM);
					return;
				end
				pr_phase = PH_SKIP;
			end
			default: pr_phase = PH_SKIP;
		endcase
	endtask

	// sender: bursts of random length, random gaps between them
	int burst_left;

	task automatic send_word(logic [1:0] cmd, logic [7:0] ch);
		if (burst_left == 0) begin
			int gap;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
		in_valid <= 1'b1;
		in_data <= '{command: cmd, char_byte: ch};
		do @(posedge clk); while (in_stall);
		parse_word(in_data);
		burst_left--;
		if (burst_left == 0) in_valid <= 1'b0;
	endtask

	// drops valid when the sender pauses in the middle of a burst
	task automatic end_burst();
		if (burst_left != 0) begin
			in_valid <= 1'b0;
			burst_left = 0;
		end
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_word(CMD_CHAR, s[i]);
	endtask

	function automatic string hex2(logic [7:0] b);
		return $sformatf("%02X", b);
	endfunction

	// one well-formed data record, checksum optionally corrupted
	function automatic string make_record(int rtype, logic [31:0] raw, int n, bit bad_sum,
			bit lower);
		string s;
		int ab;
		logic [7:0] sum, d;
		ab = rtype + 1;
		s = $sformatf("S%0d", rtype);
		sum = 8'(ab + n + 1);
		s = {s, hex2(8'(ab + n + 1))};
		for (int i = ab - 1; i >= 0; i--) begin
			d = raw[i*8 +: 8];
			sum += d;
			s = {s, hex2(d)};
		end
		for (int i = 0; i < n; i++) begin
			d = $urandom_range(0, 255);
			sum += d;
			s = {s, hex2(d)};
		end
		sum = ~sum;
		if (bad_sum) sum ^= 8'(1 << $urandom_range(0, 7));
		s = {s, hex2(sum)};
		if (lower) s = s.tolower();
		return {s, "\n"};
	endfunction

	// waits until every expected word has arrived, then lets the pipeline empty
	task automatic drain();
		end_burst();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(logic [31:0] value);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(RegMaxAddr * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		pr_max = value[18:0];
	endtask

	task automatic restart();
		send_word(CMD_RESTART, 8'h00);
	endtask

	// directed: extremes, s0/s1/s2/s3/s5/s9 records, every error and end case
	task automatic test_directed();
		restart();
		send_word(CMD_END, 8'h00);                    // no data
		restart();
		send_text("junk line\n\nS0030000FC\nS5030000FC\n");
		send_text(make_record(1, 32'h0000, 2, 0, 0));
		send_text(make_record(1, 32'hFFFF, 1, 0, 1));  // banked page
		send_text(make_record(3, 32'hFFFFFFFF, 1, 0, 0)); // maps to the last image byte
		send_word(CMD_END, 8'h00);                    // end of this file
		restart();
		send_text(make_record(2, 32'h0F3FFE, 3, 0, 0)); // crosses the top
		restart();
		send_text("S1020000");                        // short record
		restart();
		send_text(make_record(1, 32'h1234, 1, 1, 0));  // checksum error
		restart();
		send_text("S10400G");                         // bad digit
		restart();
		send_text("S1040000FF1");
		send_text("X\n");                             // bad checksum digit
		restart();
		send_text("S1050010");
		send_word(CMD_END, 8'h00);                    // end inside record
		restart();
		send_text(make_record(1, 32'h0100, 2, 0, 0));
		send_word(CMD_NOP, 8'hFF);
		send_text("S9030000FC\n");
		send_text(make_record(1, 32'h0200, 1, 0, 0)); // ignored
		send_word(CMD_END, 8'hA5);                    // done
		send_word(CMD_END, 8'h00);
	endtask

	// random: mostly well-formed files, some noise and broken records
	task automatic test_random(int n_items);
		int sent;
		string s;
		int sel;
		logic [31:0] raw;
		sent = 0;
		while (sent < n_items) begin
			sel = $urandom_range(0, 99);
			if (sel < 3) begin
				send_word(CMD_RESTART, $urandom_range(0, 255));
				s = "";
			end else if (sel < 6) begin
				send_word(CMD_END, $urandom_range(0, 255));
				s = "";
			end else if (sel < 9) begin
				send_word(CMD_NOP, $urandom_range(0, 255));
				s = "";
			end else if (sel < 14) begin
				s = "";
				repeat ($urandom_range(1, 6)) s = {s, string'(8'($urandom_range(0, 255)))};
			end else if (sel < 16) begin
				s = $sformatf("S%0d0300001\n", $urandom_range(7, 9));
			end else begin
				raw = $urandom;
				case ($urandom_range(0, 3))
					0: raw &= 32'hFFFF;
					1: raw &= 32'h3FFFF;
					2: raw &= 32'hFFFFF;
					default: ;
				endcase
				s = make_record($urandom_range(1, 3), raw, $urandom_range(0, 8),
					$urandom_range(0, 15) == 0, $urandom_range(0, 1));
			end
			if (pr_halted || pr_finished) begin
				send_word(CMD_RESTART, 8'h00);
				sent++;
			end
			send_text(s);
			sent += s.len() + 1;
		end
		send_word(CMD_END, 8'h00);
	endtask

	// receiver holds off while the sender keeps pushing two data records
	task automatic test_backpressure();
		restart();
		long_hold_cycles = 0;
		long_hold = 1'b1;
		send_text(make_record(1, 32'h0300, 16, 0, 0));
		send_text(make_record(1, 32'h0310, 16, 0, 0));
		end_burst();
		wait (!long_hold);
		send_word(CMD_END, 8'h00);
	endtask

	// receiver stall pattern and long hold counter
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (long_hold) begin
			out_stall <= 1'b1;
			long_hold_cycles <= long_hold_cycles + 1;
			if (long_hold_cycles >= 200) long_hold <= 1'b0;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2: out_stall <= 1'b1;
				default: out_stall <= 1'b0;
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			out_word_t e;
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("unexpected result word kind=%0d", out_data.kind);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (e.kind <= K_DONE) kind_seen[e.kind]++;
				if (out_data.kind !== e.kind) begin
					$error("kind exp %0d got %0d", e.kind, out_data.kind);
					errors++;
				end
				if (out_data.write_address !== e.write_address) begin
					$error("write_address exp %h got %h", e.write_address,
						out_data.write_address);
					errors++;
				end
				if (out_data.write_data !== e.write_data) begin
					$error("write_data exp %h got %h", e.write_data, out_data.write_data);
					errors++;
				end
				if (out_data.crc_value !== e.crc_value) begin
					$error("crc_value exp %h got %h", e.crc_value, out_data.crc_value);
					errors++;
				end
				if (out_data.total_bytes !== e.total_bytes) begin
					$error("total_bytes exp %0d got %0d", e.total_bytes,
						out_data.total_bytes);
					errors++;
				end
				if (out_data.line_number !== e.line_number) begin
					$error("line_number exp %0d got %0d", e.line_number,
						out_data.line_number);
					errors++;
				end
				if (out_data.lowest_address !== e.lowest_address) begin
					$error("lowest_address exp %h got %h", e.lowest_address,
						out_data.lowest_address);
					errors++;
				end
				if (out_data.highest_address !== e.highest_address) begin
					$error("highest_address exp %h got %h", e.highest_address,
						out_data.highest_address);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		results_seen = 0;
		burst_left = 0;
		long_hold = 1'b0;
		long_hold_cycles = 0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pr_max = MaxAddrReset;
		clear_parser();
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of addr_limit first
		test_directed();
		test_backpressure();
		apb_write(32'h40000);
		test_random(350);
		apb_write(32'd1);                  // only address zero allowed
		restart();
		test_directed();
		apb_write(32'h3400);               // small limit
		test_random(300);
		apb_write(32'h7FFFF);              // above the image
		test_random(250);
		drain();
		repeat (20) @(posedge clk);

		$display("covered %0d result words: writes %0d, parse %0d, address %0d,",
			results_seen, kind_seen[K_WRITE], kind_seen[K_PARSE], kind_seen[K_ADDR]);
		$display("checksum %0d, no-data %0d, done %0d over four address limit settings",
			kind_seen[K_CSUM], kind_seen[K_NONE], kind_seen[K_DONE]);
		if (errors == 0 && expected_results.size() == 0)
			$display("tb_s_record_parser_with_crc_core OK");
		else
			$display("tb_s_record_parser_with_crc_core NOT OK");
		$finish;
	end

endmodule

[sim.f]
sv/srp_pkg.sv
sv/srp_front.sv
sv/srp_back.sv
sv/s_record_parser_with_crc_core.sv
tb/tb_s_record_parser_with_crc_core.sv
